// File: src/assert_macros.svh
// Assertion helpers for the RTL, used by rhcn_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, also through reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/rhcn_pkg.sv
package rhcn_pkg;

   // Nonce length in words, default for the top level parameter
   localparam int NONCE_WORDS_DEF = 8;

   // Operation codes of a request
   localparam logic [1:0] OP_POLL  = 2'd0;
   localparam logic [1:0] OP_PRIME = 2'd1;
   localparam logic [1:0] OP_NONCE = 2'd2;

   // Status codes of a response
   localparam logic [2:0] ST_WAIT    = 3'd0;
   localparam logic [2:0] ST_WORD    = 3'd1;
   localparam logic [2:0] ST_DONE    = 3'd2;
   localparam logic [2:0] ST_PRIMED  = 3'd3;
   localparam logic [2:0] ST_FAILED  = 3'd4;
   localparam logic [2:0] ST_REFUSED = 3'd5;
   localparam logic [2:0] ST_IDLE    = 3'd6;

   // Phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_PRIME = 2'd1;
   localparam logic [1:0] PH_NONCE = 2'd2;

   // Control register port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 14;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_LIMIT    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 4'd1;

   localparam logic [13:0] POLL_LIMIT_RST    = 14'd10000;
   localparam logic [3:0]  TIMEOUT_TICKS_RST = 4'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic        source_ok;
      logic        error_flags;
      logic        data_ready;
      logic [31:0] random_word;
      logic        timer_tick;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] nonce_word;
      logic [2:0]  word_index;
      logic        last_word;
      logic        disable_source;
      logic        healthy;
   } rsp_type;

endpackage

// File: src/rhcn_in_stage.sv
module rhcn_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rhcn_pkg::req_type req_data,
   output logic             item_valid,
   output rhcn_pkg::req_type item_data,
   input  logic             item_take
);
   import rhcn_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    accept;

   // Hold off the sender only while the stored transaction cannot move on
   assign req_stall = valid_ff && !item_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

// File: src/rhcn_core.sv
`include "assert_macros.svh"

module rhcn_core #(
   parameter int NONCE_WORDS = rhcn_pkg::NONCE_WORDS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_valid,
   input  rhcn_pkg::req_type                     item_data,
   output logic                                  item_take,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rhcn_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write,
   input  logic [rhcn_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rhcn_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import rhcn_pkg::*;

   localparam int WW = (NONCE_WORDS > 1) ? $clog2(NONCE_WORDS) : 1;
   localparam logic [WW-1:0] LAST_IDX = WW'(NONCE_WORDS - 1);

   // control registers
   logic [13:0] poll_limit_ff;
   logic [3:0]  timeout_ticks_ff;

   // checker state
   logic          failed_ff, failed_in;
   logic          ready_ff, ready_in;
   logic [31:0]   ref_word_ff, ref_word_in;
   logic [1:0]    phase_ff, phase_in;
   logic [WW-1:0] words_ff, words_in;
   logic [13:0]   polls_ff, polls_in;
   logic [3:0]    ticks_ff, ticks_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [14:0]   polls_inc;
   logic [WW+2:0] idx_ext;

   assign polls_inc = {1'b0, polls_ff} + 15'd1;
   assign idx_ext   = {3'b000, words_ff};

   // Move one transaction whenever the output register is free or draining
   assign item_take = item_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (item_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Next state and response for one poll or command
   always_comb begin
      failed_in   = failed_ff;
      ready_in    = ready_ff;
      ref_word_in = ref_word_ff;
      phase_in    = phase_ff;
      words_in    = words_ff;
      polls_in    = polls_ff;
      ticks_in    = ticks_ff;
      rsp_in      = '0;
      rsp_in.status = ST_IDLE;

      case (item_data.operation)
         OP_PRIME: begin
            failed_in = 1'b1;
            ready_in  = 1'b0;
            polls_in  = '0;
            ticks_in  = '0;
            words_in  = '0;
            if (!item_data.source_ok) begin
               phase_in      = PH_IDLE;
               rsp_in.status = ST_FAILED;
            end else begin
               phase_in      = PH_PRIME;
               rsp_in.status = ST_WAIT;
            end
         end
         OP_NONCE: begin
            if (!ready_ff || failed_ff) begin
               rsp_in.status = ST_REFUSED;
            end else begin
               phase_in      = PH_NONCE;
               words_in      = '0;
               polls_in      = '0;
               ticks_in      = '0;
               rsp_in.status = ST_WAIT;
            end
         end
         OP_POLL: begin
            if (phase_ff == PH_IDLE) begin
               rsp_in.status = ST_IDLE;
            end else if (!item_data.source_ok || item_data.error_flags) begin
               failed_in = 1'b1;
               ready_in  = 1'b0;
               phase_in  = PH_IDLE;
               polls_in  = '0;
               ticks_in  = '0;
               rsp_in.status         = ST_FAILED;
               rsp_in.disable_source = 1'b1;
            end else if (item_data.data_ready) begin
               polls_in = '0;
               ticks_in = '0;
               if (phase_ff == PH_PRIME) begin
                  // first word only becomes the reference
                  ref_word_in   = item_data.random_word;
                  ready_in      = 1'b1;
                  failed_in     = 1'b0;
                  phase_in      = PH_IDLE;
                  rsp_in.status = ST_PRIMED;
               end else if (item_data.random_word == ref_word_ff) begin
                  // continuous test: repeated word
                  failed_in = 1'b1;
                  ready_in  = 1'b0;
                  phase_in  = PH_IDLE;
                  rsp_in.status         = ST_FAILED;
                  rsp_in.disable_source = 1'b1;
               end else begin
                  ref_word_in       = item_data.random_word;
                  rsp_in.nonce_word = item_data.random_word;
                  rsp_in.word_index = idx_ext[2:0];
                  if (words_ff == LAST_IDX) begin
                     phase_in         = PH_IDLE;
                     words_in         = '0;
                     rsp_in.status    = ST_DONE;
                     rsp_in.last_word = 1'b1;
                  end else begin
                     words_in      = words_ff + WW'(1);
                     rsp_in.status = ST_WORD;
                  end
               end
            end else if (item_data.timer_tick && (ticks_ff >= timeout_ticks_ff)) begin
               failed_in = 1'b1;
               ready_in  = 1'b0;
               phase_in  = PH_IDLE;
               polls_in  = '0;
               ticks_in  = '0;
               rsp_in.status         = ST_FAILED;
               rsp_in.disable_source = 1'b1;
            end else if (polls_inc >= {1'b0, poll_limit_ff}) begin
               failed_in = 1'b1;
               ready_in  = 1'b0;
               phase_in  = PH_IDLE;
               polls_in  = '0;
               ticks_in  = '0;
               rsp_in.status         = ST_FAILED;
               rsp_in.disable_source = 1'b1;
            end else begin
               if (item_data.timer_tick) begin
                  ticks_in = ticks_ff + 4'd1;
               end
               polls_in      = polls_inc[13:0];
               rsp_in.status = ST_WAIT;
            end
         end
         default: begin
            rsp_in.status = ST_IDLE;
         end
      endcase

      rsp_in.healthy = ready_in && !failed_in;
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff    <= POLL_LIMIT_RST;
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
         failed_ff        <= 1'b1;
         ready_ff         <= 1'b0;
         ref_word_ff      <= '0;
         phase_ff         <= PH_IDLE;
         words_ff         <= '0;
         polls_ff         <= '0;
         ticks_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && (csr_index == CSR_POLL_LIMIT)) begin
            poll_limit_ff <= csr_wdata[13:0];
         end
         if (csr_write && (csr_index == CSR_TIMEOUT_TICKS)) begin
            timeout_ticks_ff <= csr_wdata[3:0];
         end
         if (item_take) begin
            failed_ff   <= failed_in;
            ready_ff    <= ready_in;
            ref_word_ff <= ref_word_in;
            phase_ff    <= phase_in;
            words_ff    <= words_in;
            polls_ff    <= polls_in;
            ticks_ff    <= ticks_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `ASSERT_CLK_RST(a_word_only_on_accept, clock, reset, (rsp_valid_ff && rsp_ff.status != ST_WORD && rsp_ff.status != ST_DONE) |-> (rsp_ff.nonce_word == 32'd0), "nonce word leaked on a non-word response")
   `ASSERT_CLK_RST(a_last_with_done, clock, reset, rsp_valid_ff |-> (rsp_ff.last_word == (rsp_ff.status == ST_DONE)), "last word flag out of step with status")
   `ASSERT_CLK_RST(a_disable_on_fail, clock, reset, (rsp_valid_ff && rsp_ff.disable_source) |-> (rsp_ff.status == ST_FAILED && !rsp_ff.healthy), "disable request without failure")
   `ASSERT_CLK(a_empty_after_reset, clock, $past(reset) |-> !rsp_valid_ff, "response valid right after reset")

endmodule

// File: src/rng_health_checked_nonce.sv
// Health-checked nonce builder on a hardware random source.
// Request channel (req_valid / req_stall / req_data): one transaction per poll
// of the source or per command (prime, request nonce). Response channel
// (rsp_valid / rsp_stall / rsp_data): exactly one transaction per request,
// in order, giving status, an accepted nonce word with its index, the last
// word flag, a source disable request and the health flag.
// Control port (csr_valid / csr_ready / csr_index / csr_wdata): index 0 sets
// the poll limit, index 1 the timeout tick count; always ready. The port must be
// written only while no request is in flight: the user is bound by this, the
// block itself does not enforce it. An accepted request is held in the input
// register, and its response is then registered in the response register.
// Throughput is one request per cycle while the receiver does not stall: the
// check and count logic sits between the input and response registers.
// Reset clears both stages, marks the block failed and unprimed, and loads
// the default limits (10000 polls, 2 ticks). When the receiver stalls, the
// response holds, the input register holds one more request, and then
// req_stall rises until the response is taken.
module rng_health_checked_nonce #(
   parameter int NONCE_WORDS = rhcn_pkg::NONCE_WORDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rhcn_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rhcn_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rhcn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rhcn_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rhcn_pkg::*;

   logic    item_valid;
   req_type item_data;
   logic    item_take;

   // control writes always accepted
   assign csr_ready = 1'b1;

   rhcn_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take)
   );

   rhcn_core #(
      .NONCE_WORDS (NONCE_WORDS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import rhcn_pkg::*;

   localparam int NWORDS      = NONCE_WORDS_DEF;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 320;

   // Operation code with no command behind it, and an index with no register
   localparam logic [1:0]             OP_UNUSED    = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 4'd15;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rng_health_checked_nonce #(.NONCE_WORDS(NWORDS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog
   int cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Health checker state and limits as the block should hold them
   bit          mdl_failed;
   bit          mdl_ready;
   logic [31:0] mdl_ref;
   logic [1:0]  mdl_phase;
   int          mdl_taken;
   int          mdl_polls;
   int          mdl_ticks;
   int          cfg_poll_limit;
   int          cfg_timeout;

   rsp_type pending_nonce_rsp[$];

   int errors      = 0;
   int items_sent  = 0;
   int rsp_seen    = 0;
   int nonces_done = 0;
   int trips       = 0;
   int settings    = 1;
   bit idle_on     = 1'b1;
   int hold_cycles = 0;

   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type rs;
   } dir_row_type;

   dir_row_type dir_rows[$];

   task automatic report(input string msg);
      errors++;
      if (errors <= 20)
         $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Next response of the health checker for one request; updates state
   function automatic rsp_type nonce_predict(input req_type rq);
      rsp_type rs;
      bit      trip;
      rs   = '0;
      trip = 1'b0;
      if (rq.operation == OP_PRIME) begin
         mdl_failed = 1'b1;
         mdl_ready  = 1'b0;
         mdl_polls  = 0;
         mdl_ticks  = 0;
         mdl_taken  = 0;
         if (!rq.source_ok) begin
            mdl_phase = PH_IDLE;
            rs.status = ST_FAILED;
         end else begin
            mdl_phase = PH_PRIME;
            rs.status = ST_WAIT;
         end
      end else if (rq.operation == OP_NONCE) begin
         if (!mdl_ready || mdl_failed) begin
            rs.status = ST_REFUSED;
         end else begin
            mdl_phase = PH_NONCE;
            mdl_taken = 0;
            mdl_polls = 0;
            mdl_ticks = 0;
            rs.status = ST_WAIT;
         end
      end else if (rq.operation != OP_POLL || mdl_phase == PH_IDLE) begin
         rs.status = ST_IDLE;
      end else if (!rq.source_ok || rq.error_flags) begin
         trip = 1'b1;
      end else if (rq.data_ready) begin
         mdl_polls = 0;
         mdl_ticks = 0;
         if (mdl_phase == PH_PRIME) begin
            // reference word is captured, not compared
            mdl_ref    = rq.random_word;
            mdl_ready  = 1'b1;
            mdl_failed = 1'b0;
            mdl_phase  = PH_IDLE;
            rs.status  = ST_PRIMED;
         end else if (rq.random_word == mdl_ref) begin
            trip = 1'b1;
         end else begin
            mdl_ref       = rq.random_word;
            rs.nonce_word = rq.random_word;
            rs.word_index = 3'(mdl_taken);
            if (mdl_taken + 1 >= NWORDS) begin
               mdl_phase    = PH_IDLE;
               mdl_taken    = 0;
               rs.status    = ST_DONE;
               rs.last_word = 1'b1;
            end else begin
               mdl_taken = mdl_taken + 1;
               rs.status = ST_WORD;
            end
         end
      end else if (rq.timer_tick && mdl_ticks >= cfg_timeout) begin
         trip = 1'b1;
      end else begin
         // tick count first, then poll count; a zero limit acts like one
         if (rq.timer_tick)
            mdl_ticks = (mdl_ticks + 1) & 15;
         if (mdl_polls + 1 >= cfg_poll_limit) begin
            trip = 1'b1;
         end else begin
            mdl_polls = (mdl_polls + 1) & 16383;
            rs.status = ST_WAIT;
         end
      end
      if (trip) begin
         mdl_failed        = 1'b1;
         mdl_ready         = 1'b0;
         mdl_phase         = PH_IDLE;
         mdl_polls         = 0;
         mdl_ticks         = 0;
         rs.status         = ST_FAILED;
         rs.disable_source = 1'b1;
      end
      rs.healthy = mdl_ready && !mdl_failed;
      return rs;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input bit ok, input bit err,
                                        input bit rdy, input logic [31:0] w, input bit tick);
      req_type rq;
      rq.operation   = op;
      rq.source_ok   = ok;
      rq.error_flags = err;
      rq.data_ready  = rdy;
      rq.random_word = w;
      rq.timer_tick  = tick;
      return rq;
   endfunction

   function automatic rsp_type plain_rsp(input logic [2:0] st, input bit dis, input bit hl);
      rsp_type rs;
      rs                = '0;
      rs.status         = st;
      rs.disable_source = dis;
      rs.healthy        = hl;
      return rs;
   endfunction

   // Random request, mostly following a well-formed prime / nonce sequence
   function automatic req_type next_stimulus();
      req_type rq;
      int      roll;
      rq   = make_req(OP_POLL, 1'b1, 1'b0, 1'b0, $urandom, 1'($urandom_range(0, 1)));
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         // noise: any field combination
         rq.operation   = 2'($urandom_range(0, 3));
         rq.source_ok   = 1'($urandom_range(0, 1));
         rq.error_flags = 1'($urandom_range(0, 1));
         rq.data_ready  = 1'($urandom_range(0, 1));
      end else if (mdl_phase == PH_IDLE) begin
         if (mdl_ready && !mdl_failed && roll < 75) begin
            rq.operation = OP_NONCE;
         end else begin
            rq.operation = OP_PRIME;
            rq.source_ok = ($urandom_range(0, 19) != 0);
         end
         rq.data_ready = 1'($urandom_range(0, 1));
      end else if (roll < 7) begin
         // restart in the middle of a wait
         rq.operation = ($urandom_range(0, 1) != 0) ? OP_PRIME : OP_NONCE;
      end else begin
         rq.source_ok   = ($urandom_range(0, 59) != 0);
         rq.error_flags = ($urandom_range(0, 59) == 0);
         rq.data_ready  = ($urandom_range(0, 99) < 45);
         rq.timer_tick  = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 29) == 0)
            rq.random_word = mdl_ref;
      end
      return rq;
   endfunction

   // Offer one request and record its expected response once accepted
   task automatic send_req(input req_type rq, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type want;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = nonce_predict(rq);
      pending_nonce_rsp.push_back(typed ? typed_rsp : want);
      items_sent++;
   endtask

   // Let the block run dry before touching its registers
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_nonce_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Register write; valid stays high for back-to-back writes
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_POLL_LIMIT)
         cfg_poll_limit = val;
      else if (idx == CSR_TIMEOUT_TICKS)
         cfg_timeout = val & 14'hF;
   endtask

   // Input defaults and reset
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
   end

   // Response side: random stalls, one long hold on request, field checks
   initial begin
      int      n;
      rsp_type want;
      rsp_type got;
      rsp_stall <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         n = idle_on ? $urandom_range(0, 7) : 0;
         if (hold_cycles > 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got = rsp_data;
         rsp_seen++;
         if (got.status == ST_DONE)
            nonces_done++;
         if (got.status == ST_FAILED)
            trips++;
         if (pending_nonce_rsp.size() == 0) begin
            report($sformatf("unexpected response status %0d", got.status));
         end else begin
            want = pending_nonce_rsp.pop_front();
            if (got.status !== want.status)
               report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.nonce_word !== want.nonce_word)
               report($sformatf("nonce_word %h, want %h", got.nonce_word, want.nonce_word));
            if (got.word_index !== want.word_index)
               report($sformatf("word_index %0d, want %0d", got.word_index, want.word_index));
            if (got.last_word !== want.last_word)
               report($sformatf("last_word %b, want %b", got.last_word, want.last_word));
            if (got.disable_source !== want.disable_source)
               report($sformatf("disable_source %b, want %b",
                                got.disable_source, want.disable_source));
            if (got.healthy !== want.healthy)
               report($sformatf("healthy %b, want %b", got.healthy, want.healthy));
         end
      end
   end

   // Stimulus
   initial begin
      int               plims[6];
      logic [13:0]      ticks_data[6];
      dir_row_type      row;

      mdl_failed     = 1'b1;
      mdl_ready      = 1'b0;
      mdl_ref        = '0;
      mdl_phase      = PH_IDLE;
      mdl_taken      = 0;
      mdl_polls      = 0;
      mdl_ticks      = 0;
      cfg_poll_limit = POLL_LIMIT_RST;
      cfg_timeout    = TIMEOUT_TICKS_RST;

      plims      = '{1, 0, 16383, 3, 40, 10000};
      ticks_data = '{14'd0, 14'd15, 14'd15, 14'd1, 14'h3FF5, 14'd2};

      // Directed rows under the reset limits
      row.typed = 1'b1;
      row.rq = make_req(OP_POLL, 1, 0, 1, 32'h1234_5678, 1);
      row.rs = plain_rsp(ST_IDLE, 0, 0);     dir_rows.push_back(row);
      row.rq = make_req(OP_UNUSED, 1, 0, 1, 32'hFFFF_FFFF, 0);
      row.rs = plain_rsp(ST_IDLE, 0, 0);     dir_rows.push_back(row);
      row.rq = make_req(OP_NONCE, 1, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_REFUSED, 0, 0);  dir_rows.push_back(row);
      row.rq = make_req(OP_PRIME, 0, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_FAILED, 0, 0);   dir_rows.push_back(row);
      row.rq = make_req(OP_PRIME, 1, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_WAIT, 0, 0);     dir_rows.push_back(row);
      row.rq = make_req(OP_POLL, 0, 0, 1, 32'hA5A5_A5A5, 0);
      row.rs = plain_rsp(ST_FAILED, 1, 0);   dir_rows.push_back(row);
      row.rq = make_req(OP_PRIME, 1, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_WAIT, 0, 0);     dir_rows.push_back(row);
      row.rq = make_req(OP_POLL, 1, 1, 1, 32'h5A5A_5A5A, 0);
      row.rs = plain_rsp(ST_FAILED, 1, 0);   dir_rows.push_back(row);
      row.rq = make_req(OP_PRIME, 1, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_WAIT, 0, 0);     dir_rows.push_back(row);
      // prime again while priming restarts the wait
      row.rq = make_req(OP_PRIME, 1, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_WAIT, 0, 0);     dir_rows.push_back(row);
      // tick timeout: the third tick is one over the limit of two
      row.rq = make_req(OP_POLL, 1, 0, 0, 32'h0, 1);
      row.rs = plain_rsp(ST_WAIT, 0, 0);     dir_rows.push_back(row);
      row.rq = make_req(OP_POLL, 1, 0, 0, 32'h0, 1);
      row.rs = plain_rsp(ST_WAIT, 0, 0);     dir_rows.push_back(row);
      row.rq = make_req(OP_POLL, 1, 0, 0, 32'h0, 1);
      row.rs = plain_rsp(ST_FAILED, 1, 0);   dir_rows.push_back(row);
      row.rq = make_req(OP_PRIME, 1, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_WAIT, 0, 0);     dir_rows.push_back(row);
      row.rq = make_req(OP_POLL, 1, 0, 1, 32'hFFFF_FFFF, 1);
      row.rs = plain_rsp(ST_PRIMED, 0, 1);   dir_rows.push_back(row);
      row.rq = make_req(OP_NONCE, 1, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_WAIT, 0, 1);     dir_rows.push_back(row);
      // repeated word fails the continuous test
      row.rq = make_req(OP_POLL, 1, 0, 1, 32'hFFFF_FFFF, 0);
      row.rs = plain_rsp(ST_FAILED, 1, 0);   dir_rows.push_back(row);
      row.rq = make_req(OP_PRIME, 1, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_WAIT, 0, 0);     dir_rows.push_back(row);
      row.rq = make_req(OP_POLL, 1, 0, 1, 32'h0000_0000, 0);
      row.rs = plain_rsp(ST_PRIMED, 0, 1);   dir_rows.push_back(row);
      row.rq = make_req(OP_NONCE, 1, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_WAIT, 0, 1);     dir_rows.push_back(row);
      row.typed = 1'b0;
      row.rq = make_req(OP_POLL, 1, 0, 1, 32'h8000_0000, 0);   dir_rows.push_back(row);
      // nonce request mid-nonce restarts at word zero
      row.typed = 1'b1;
      row.rq = make_req(OP_NONCE, 1, 0, 0, 32'h0, 0);
      row.rs = plain_rsp(ST_WAIT, 0, 1);     dir_rows.push_back(row);
      row.typed = 1'b0;
      for (int i = 0; i < NWORDS; i++) begin
         row.rq = make_req(OP_POLL, 1, 0, 1, (i % 2) ? 32'h0000_0001 << i : ~(32'h1 << i),
                           1'(i % 2));
         dir_rows.push_back(row);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs);

      // Random phases, each under its own limit setting
      for (int ph = 0; ph < 6; ph++) begin
         settle_block();
         write_csr(CSR_POLL_LIMIT, 14'(plims[ph]));
         write_csr(CSR_TIMEOUT_TICKS, ticks_data[ph]);
         if (ph == 4)
            write_csr(CSR_UNMAPPED, 14'($urandom));
         csr_valid <= 1'b0;
         settings++;
         if (ph == 3)
            hold_cycles = 300;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 40 == 0)
               idle_on = ($urandom_range(0, 3) != 0);
            send_req(next_stimulus(), 1'b0, '0);
         end
      end

      settle_block();
      $display("Sent %0d requests under %0d limit settings, checked %0d responses",
               items_sent, settings, rsp_seen);
      $display("Built %0d complete nonces, saw %0d health failures",
               nonces_done, trips);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
